// File: rtl/a2ss_pkg.sv
`timescale 1ns / 1ps

package a2ss_pkg;

  localparam int DIGITS_DEFAULT = 6;
  localparam int CHAR_W         = 8;
  localparam int SEG_W          = 8;
  localparam int CNT_W          = 5;

  localparam logic [SEG_W-1:0] SG_A = 8'h01;
  localparam logic [SEG_W-1:0] SG_B = 8'h02;
  localparam logic [SEG_W-1:0] SG_C = 8'h04;
  localparam logic [SEG_W-1:0] SG_D = 8'h08;
  localparam logic [SEG_W-1:0] SG_E = 8'h10;
  localparam logic [SEG_W-1:0] SG_F = 8'h20;
  localparam logic [SEG_W-1:0] SG_G = 8'h40;
  localparam logic [SEG_W-1:0] SG_P = 8'h80;

  localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_PAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture_cur;
    logic hold_load;
    logic emit_held;
    logic emit_cur;
    logic emit_pad;
    logic set_latch;
    logic clear_string;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic held_emit;
    logic in_dot;
    logic sent_full;
    logic sent_near_full;
  } status_t;

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CHAR_W-1:0] ch);
    logic [SEG_W-1:0] seg;
    unique case (ch)
      8'd45:   seg = SG_G;
      8'd48:   seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      8'd49:   seg = SG_B | SG_C;
      8'd50:   seg = SG_A | SG_B | SG_G | SG_D | SG_E;
      8'd51:   seg = SG_A | SG_B | SG_C | SG_D | SG_G;
      8'd52:   seg = SG_F | SG_G | SG_B | SG_C;
      8'd53:   seg = SG_A | SG_F | SG_C | SG_D | SG_G;
      8'd54:   seg = SG_A | SG_F | SG_C | SG_D | SG_G | SG_E;
      8'd55:   seg = SG_A | SG_B | SG_C;
      8'd56:   seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G;
      8'd57:   seg = SG_A | SG_B | SG_C | SG_D | SG_F | SG_G;
      8'd58:   seg = SG_P;
      8'd69:   seg = SG_A | SG_D | SG_E | SG_F | SG_G;
      8'd83:   seg = SG_A | SG_C | SG_D | SG_F | SG_G;
      8'd99:   seg = SG_D | SG_E | SG_G;
      8'd100:  seg = SG_B | SG_C | SG_D | SG_E | SG_G;
      8'd114:  seg = SG_E | SG_G;
      8'd117:  seg = SG_C | SG_D | SG_E;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/a2ss_ctrl.sv
`timescale 1ns / 1ps

module a2ss_ctrl
  import a2ss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last_char,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !status.out_free;
        accept   = in_valid && status.out_free;
        if (accept) begin
          cmd.capture_cur = 1'b1;
          cmd.emit_held   = status.held_emit;
          if (!in_last_char) begin
            cmd.hold_load = 1'b1;
          end else if (!status.in_dot) begin
            state_nxt = ST_CUR;
          end else if (status.held_emit ? status.sent_near_full : status.sent_full) begin
            // held byte with its point is the final byte
            cmd.set_latch    = 1'b1;
            cmd.clear_string = 1'b1;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_CUR: begin
        if (status.out_free) begin
          cmd.emit_cur = 1'b1;
          if (status.sent_near_full) begin
            cmd.set_latch    = 1'b1;
            cmd.clear_string = 1'b1;
            state_nxt        = ST_IDLE;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (status.out_free) begin
          cmd.emit_pad = 1'b1;
          if (status.sent_near_full) begin
            cmd.set_latch    = 1'b1;
            cmd.clear_string = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/a2ss_datapath.sv
`timescale 1ns / 1ps

module a2ss_datapath
  import a2ss_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [SEG_W-1:0]  out_segments,
  output logic              out_latch,
  input  cmd_t              cmd,
  output status_t           status
);

  localparam logic [CNT_W-1:0] DIGITS_C    = CNT_W'(DIGITS);
  localparam logic [CNT_W-1:0] DIGITS_M1_C = CNT_W'(DIGITS - 1);

  logic [CHAR_W-1:0] held_char_r;
  logic [CHAR_W-1:0] held_char_nxt;
  logic              held_valid_r;
  logic              held_valid_nxt;
  logic [CNT_W-1:0]  sent_count_r;
  logic [CNT_W-1:0]  sent_count_nxt;
  logic [CHAR_W-1:0] cur_char_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [SEG_W-1:0]  out_segments_r;
  logic              out_latch_r;
  logic [SEG_W-1:0]  emit_byte;
  logic              emit_any;
  logic              in_dot;

  assign in_dot   = (in_character == DOT_CHAR);
  assign emit_any = cmd.emit_held || cmd.emit_cur || cmd.emit_pad;

  assign status.out_free       = !out_valid_r || !out_stall;
  assign status.in_dot         = in_dot;
  assign status.held_emit      = held_valid_r && (in_dot || (held_char_r != DOT_CHAR));
  assign status.sent_full      = (sent_count_r >= DIGITS_C);
  assign status.sent_near_full = (sent_count_r >= DIGITS_M1_C);

  always_comb begin
    priority if (cmd.emit_held) begin
      emit_byte = seg_lookup(held_char_r) | (in_dot ? SG_P : '0);
    end else if (cmd.emit_cur) begin
      emit_byte = seg_lookup(cur_char_r);
    end else begin
      emit_byte = seg_lookup(BLANK_CHAR);
    end
  end

  always_comb begin
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    sent_count_nxt = sent_count_r;
    if (emit_any && (sent_count_r < DIGITS_C)) begin
      sent_count_nxt = sent_count_r + CNT_W'(1);
    end
    if (cmd.hold_load) begin
      held_char_nxt  = in_character;
      held_valid_nxt = 1'b1;
    end
    if (cmd.clear_string) begin
      held_char_nxt  = '0;
      held_valid_nxt = 1'b0;
      sent_count_nxt = '0;
    end
    out_valid_nxt = emit_any || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      sent_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      sent_count_r <= sent_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmd.capture_cur) begin
      cur_char_r <= in_character;
    end
    if (emit_any) begin
      out_segments_r <= emit_byte;
      out_latch_r    <= cmd.set_latch;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_segments = out_segments_r;
  assign out_latch    = out_latch_r;

`ifndef ASSERT_OFF
  a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_held, cmd.emit_cur, cmd.emit_pad}))
    else $error("more than one byte source selected");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> (!out_valid_r || !out_stall))
    else $error("byte emitted over a stalled output item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sent_count_r <= DIGITS_C)
    else $error("sent count beyond digit count");

  a_clear_string: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_string |=> (sent_count_r == '0) && !held_valid_r)
    else $error("string state not cleared after final byte");

  a_latch_with_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_latch |-> emit_any && cmd.clear_string)
    else $error("latch marked without a final byte");
`endif

endmodule

// File: rtl/ascii_to_seven_segment_stream_core.sv
`timescale 1ns / 1ps

// ASCII to seven-segment stream encoder.
// Input channel (in_valid / in_stall): one ASCII character per item, with
//   in_last_char high on the final character of a string.
// Output channel (out_valid / out_stall): one segment byte per item, bit 0 is
//   segment a through bit 6 segment g, bit 7 the decimal point. out_latch is
//   high on the final byte of each string.
// One character is held back as lookahead so that a following '.' can merge
//   into its point bit; a byte therefore leaves when the next character is
//   taken and, being registered, shows on out_segments in the following cycle.
// Throughput: one character per cycle in the body of a string while the output
//   is free. On the final character the input stalls while the block emits
//   the final character's own byte (none for a point) and blank padding up to
//   DIGITS bytes, issued by the padding sequencer.
// Reset (rst_n low, synchronous) drops any held character, clears the byte
//   count and empties the output register.
// A stall on the output holds the output register; the input then stalls too.
module ascii_to_seven_segment_stream_core
  import a2ss_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              in_last_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SEG_W-1:0]  out_segments,
  output logic              out_latch
);

  cmd_t    cmd;
  status_t status;

  // Sequence each string: accept, emit the final byte, pad, latch
  a2ss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Hold the lookahead character, count bytes, drive the output register
  a2ss_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_character (in_character),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_segments (out_segments),
    .out_latch    (out_latch),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// File: bench/a2ss_stream_checker.sv
`timescale 1ns / 1ps

module a2ss_stream_checker
  import a2ss_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              in_last_char,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [SEG_W-1:0]  out_segments,
  input  logic              out_latch,
  output int                mismatches,
  output int                outstanding,
  output int                bytes_checked
);

  typedef struct {
    logic [SEG_W-1:0] segments;
    logic             latch;
  } seg_byte_t;

  seg_byte_t         pending_bytes[$];
  seg_byte_t         oldest;
  logic [CHAR_W-1:0] held_char;
  logic              held_valid;
  logic [CNT_W-1:0]  sent_count;
  int                error_total;
  int                checked_total;

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    bytes_checked = 0;
    error_total   = 0;
    checked_total = 0;
    held_char     = '0;
    held_valid    = 1'b0;
    sent_count    = '0;
  end

  function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] ch);
    case (ch)
      "-":     return SG_G;
      "0":     return SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      "1":     return SG_B | SG_C;
      "2":     return SG_A | SG_B | SG_D | SG_E | SG_G;
      "3":     return SG_A | SG_B | SG_C | SG_D | SG_G;
      "4":     return SG_B | SG_C | SG_F | SG_G;
      "5":     return SG_A | SG_C | SG_D | SG_F | SG_G;
      "6":     return SG_A | SG_C | SG_D | SG_E | SG_F | SG_G;
      "7":     return SG_A | SG_B | SG_C;
      "8":     return SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G;
      "9":     return SG_A | SG_B | SG_C | SG_D | SG_F | SG_G;
      ":":     return SG_P;
      "E":     return SG_A | SG_D | SG_E | SG_F | SG_G;
      "S":     return SG_A | SG_C | SG_D | SG_F | SG_G;
      "c":     return SG_D | SG_E | SG_G;
      "d":     return SG_B | SG_C | SG_D | SG_E | SG_G;
      "r":     return SG_E | SG_G;
      "u":     return SG_C | SG_D | SG_E;
      default: return '0;
    endcase
  endfunction

  task automatic queue_byte(input logic [SEG_W-1:0] seg);
    seg_byte_t b;
    b.segments = seg;
    b.latch    = 1'b0;
    pending_bytes.push_back(b);
    if (sent_count < DIGITS) sent_count++;
  endtask

  // Work out the bytes one accepted character releases.
  task automatic encode_char(input logic [CHAR_W-1:0] ch, input logic last);
    int first_new;
    first_new = pending_bytes.size();
    if (held_valid) begin
      if (ch == DOT_CHAR) queue_byte(glyph(held_char) | SG_P);
      else if (held_char != DOT_CHAR) queue_byte(glyph(held_char));
    end
    if (!last) begin
      held_char  = ch;
      held_valid = 1'b1;
    end else begin
      if (ch != DOT_CHAR) queue_byte(glyph(ch));
      while (sent_count < DIGITS) queue_byte(glyph(BLANK_CHAR));
      if (pending_bytes.size() > first_new)
        pending_bytes[pending_bytes.size()-1].latch = 1'b1;
      held_char  = '0;
      held_valid = 1'b0;
      sent_count = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_bytes.delete();
      held_char  = '0;
      held_valid = 1'b0;
      sent_count = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected byte: segments %h latch %b", out_segments, out_latch);
          error_total++;
        end else begin
          oldest = pending_bytes.pop_front();
          checked_total++;
          if (out_segments !== oldest.segments) begin
            $error("segments: expected %h, actual %h", oldest.segments, out_segments);
            error_total++;
          end
          if (out_latch !== oldest.latch) begin
            $error("latch: expected %b, actual %b", oldest.latch, out_latch);
            error_total++;
          end
        end
      end
      if (in_valid && !in_stall) encode_char(in_character, in_last_char);
    end
    mismatches    <= error_total;
    outstanding   <= pending_bytes.size();
    bytes_checked <= checked_total;
  end

endmodule

// File: bench/ascii_to_seven_segment_stream_core_tb.sv
`timescale 1ns / 1ps

module ascii_to_seven_segment_stream_core_tb
  import a2ss_pkg::*;
();

  localparam int DIGITS      = DIGITS_DEFAULT;
  localparam int PHASE_ITEMS = 60;       // minimum random characters per idling phase
  localparam int LONG_HOLD   = 48;       // cycles of the long output hold-off
  localparam int DRAIN       = DIGITS + 8;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CHAR_W-1:0] in_character;
  logic              in_last_char;
  logic              out_valid;
  logic              out_stall;
  logic [SEG_W-1:0]  out_segments;
  logic              out_latch;

  int mismatches;
  int outstanding;
  int bytes_checked;

  // Idling knobs, in percent of cycles.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic long_hold_req  = 1'b0;

  int items_sent   = 0;
  int strings_sent = 0;
  int cycle_count  = 0;

  // Characters the display knows, plus space; the rest of the byte range
  // comes from plain random codes.
  string known_chars = "-0123456789:ESdcru ";

  ascii_to_seven_segment_stream_core #(
    .DIGITS(DIGITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_character(in_character),
    .in_last_char(in_last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_segments(out_segments),
    .out_latch   (out_latch)
  );

  a2ss_stream_checker #(
    .DIGITS(DIGITS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_segments (out_segments),
    .out_latch    (out_latch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .bytes_checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random per cycle; on request hold off for a long
  // stretch so the block fills up and backs up into its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: give up if the run hangs.
  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offer one item; idle first at the sender's rate, then hold the item
  // until the block takes it.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  // Mostly known characters, a good share of points to exercise merging,
  // and the odd arbitrary code.
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 55) return known_chars[$urandom_range(known_chars.len() - 1)];
    if (r < 78) return DOT_CHAR;
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic send_random_string(input int len);
    for (int i = 0; i < len; i++) send_item(pick_char(), i == len - 1);
  endtask

  // Short strings dominate; some fill the display, a few overrun it.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 5);
    if (r < 93) return $urandom_range(6, 9);
    return $urandom_range(10, 16);
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    target         = items_sent + PHASE_ITEMS;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent < target) send_random_string(pick_length());
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_character <= '0;
    in_last_char <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings, no idling.
    send_text("-");          // lone character, all padding after it
    send_text(".1");         // leading point is dropped
    send_text("1..2");       // point merges, second point stands alone
    send_text("E.");         // point on the final item
    send_text(".");          // string with no bytes of its own
    send_text("012345678");  // longer than the display, no padding
    send_item(8'h00, 1'b0);  // field extremes, both unknown codes
    send_item(8'hFF, 1'b1);
    send_text("S:u");

    // Random strings over the idling phases; fill the block once while the
    // receiver holds off.
    run_phase(0, 0);
    long_hold_req = 1'b1;
    send_random_string(16);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(22, 22);

    // Drop valid, release the receiver and drain.
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d characters in %0d strings, checked %0d segment bytes.",
             items_sent, strings_sent, bytes_checked);
    $display("Covered point merging, dropped and doubled points, padding, "
             , "overlong strings and a long output hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: ascii_to_seven_segment_stream_core.f
rtl/a2ss_pkg.sv
rtl/a2ss_ctrl.sv
rtl/a2ss_datapath.sv
rtl/ascii_to_seven_segment_stream_core.sv
bench/a2ss_stream_checker.sv
bench/ascii_to_seven_segment_stream_core_tb.sv
